// ----- src/fgn_pkg.sv -----
// shared types and constants for the fractal gradient noise unit
`timescale 1ns / 1ps

package fgn_pkg;

  localparam int COORD_W  = 32;
  localparam int FREQ_W   = 28;
  localparam int AMP_W    = 17;
  localparam int TOTAL_W  = 43;
  localparam int WGT_W    = 22;
  localparam int NOISE_W  = 18;
  localparam int QUOT_W   = 19;
  localparam int CNT_W    = 4;
  localparam int GAIN_W   = 16;
  localparam int SEED_W   = 32;

  localparam logic [FREQ_W-1:0] FREQ_ONE = 28'd4096;
  localparam logic [FREQ_W-1:0] FREQ_SAT = 28'hFFFFFFF;
  localparam logic [AMP_W-1:0]  AMP_ONE  = 17'd65536;

  localparam logic [31:0] HASH_C1 = 32'd374761393;
  localparam logic [31:0] HASH_C2 = 32'd668265263;
  localparam logic [31:0] HASH_C3 = 32'd1274126177;
  localparam int          HASH_SHIFT = 13;

  localparam logic signed [NOISE_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [NOISE_W-1:0] OUT_MIN = 18'sh20000;

  typedef enum logic [1:0] {
    CFG_OCTAVES   = 2'd0,
    CFG_FREQ_GAIN = 2'd1,
    CFG_AMP_GAIN  = 2'd2,
    CFG_SEED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]  octave_count;
    logic [GAIN_W-1:0] freq_gain;
    logic [GAIN_W-1:0] amp_gain;
    logic [SEED_W-1:0] seed;
  } cfg_t;

  // per-sample state that walks down the octave chain
  typedef struct packed {
    logic                       vld;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [FREQ_W-1:0]          freq;
    logic [AMP_W-1:0]           amp;
    logic [AMP_W-1:0]           amp_nx;
    logic signed [TOTAL_W-1:0]  total;
    logic [WGT_W-1:0]           weight;
  } item_t;

endpackage

// ----- src/fractal_gradient_noise_2d_unit.sv -----
// top level of the fractal gradient noise unit: config registers, octave chain, divider
`timescale 1ns / 1ps
// pipeline: seven stages per octave, a 21-stage divider whose last stage is the output register
// throughput: one transaction per cycle; the whole pipeline holds only while a
//   finished result sits in the output register under stall
// reset: pipeline valids clear, registers return to 4 octaves, gain 2.0, persistence 0.5, seed 0

module fractal_gradient_noise_2d_unit #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write port
  input  logic                                  cfg_write,
  input  logic [1:0]                            cfg_index,
  input  logic [fgn_pkg::SEED_W-1:0]            cfg_data,
  // sample input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fgn_pkg::COORD_W-1:0]    coord_x,
  input  logic signed [fgn_pkg::COORD_W-1:0]    coord_y,
  // noise output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fgn_pkg::NOISE_W-1:0]    noise_value
);
  import fgn_pkg::*;

  cfg_t  cfg;
  item_t head;
  item_t chain [MAX_OCTAVES+1];
  logic  adv;

  // config registers; writes must only arrive while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.octave_count <= 4'd4;
      cfg.freq_gain    <= 16'd8192;
      cfg.amp_gain     <= 16'd32768;
      cfg.seed         <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OCTAVES:   cfg.octave_count <= cfg_data[CNT_W-1:0];
        CFG_FREQ_GAIN: cfg.freq_gain    <= cfg_data[GAIN_W-1:0];
        CFG_AMP_GAIN:  cfg.amp_gain     <= cfg_data[GAIN_W-1:0];
        CFG_SEED:      cfg.seed         <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // octave 0 starts at unit frequency and amplitude
  always_comb begin
    head.vld    = in_valid;
    head.cx     = coord_x;
    head.cy     = coord_y;
    head.freq   = FREQ_ONE;
    head.amp    = AMP_ONE;
    head.amp_nx = AMP_ONE;
    head.total  = '0;
    head.weight = '0;
  end

  assign chain[0] = head;

  // octaves past the configured count pass their sums through untouched
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fgn_octave #(
      .OCT_IDX (i)
    ) u_oct (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .cfg      (cfg),
      .in_item  (chain[i]),
      .out_item (chain[i+1])
    );
  end

  // normalize by twice the weight sum; zero weight gives zero
  fgn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_vld    (chain[MAX_OCTAVES].vld),
    .in_total  (chain[MAX_OCTAVES].total),
    .in_weight (chain[MAX_OCTAVES].weight),
    .out_vld   (out_valid),
    .out_value (noise_value)
  );

endmodule

// ----- src/fgn_octave.sv -----
// one noise octave: split, hash, fade, gradients, blend and weighted accumulate
`timescale 1ns / 1ps

module fgn_octave #(
  parameter int unsigned OCT_IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fgn_pkg::cfg_t  cfg,
  input  fgn_pkg::item_t in_item,
  output fgn_pkg::item_t out_item
);
  import fgn_pkg::*;

  localparam int PROD_W = 61;
  localparam int GRAD_W = 19;
  localparam int BL_W   = 20;
  // low three hash bits only see bits 0..20 of the lattice indexes and seed
  localparam int HASH_W = 21;

  function automatic logic [2:0] corner_sel(input logic [HASH_W-1:0] lx,
                                            input logic [HASH_W-1:0] ly,
                                            input logic [HASH_W-1:0] seed);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] m;
    logic [HASH_W-1:0] p;
    h = seed ^ (lx * HASH_C1[HASH_W-1:0]) ^ (ly * HASH_C2[HASH_W-1:0]);
    m = h ^ (h >> HASH_SHIFT);
    p = m * HASH_C3[HASH_W-1:0];
    return p[2:0];
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad(input logic [2:0] g,
                                                    input logic signed [17:0] x,
                                                    input logic signed [17:0] y);
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = g[2] ? GRAD_W'(y) : GRAD_W'(x);
    v = g[2] ? GRAD_W'(x) : GRAD_W'(y);
    return (g[0] ? -u : u) + (g[1] ? -v : v);
  endfunction

  function automatic logic signed [BL_W-1:0] blend(input logic signed [BL_W-1:0] a,
                                                   input logic signed [BL_W-1:0] b,
                                                   input logic [16:0] t);
    logic signed [BL_W:0]  d;
    logic signed [38:0]    p;
    logic signed [38:0]    s;
    d = (BL_W+1)'(b) - (BL_W+1)'(a);
    p = d * $signed({1'b0, t});
    s = p >>> 16;
    return a + $signed(s[BL_W-1:0]);
  endfunction

  // t^3 in q0.16
  function automatic logic [15:0] cube(input logic [15:0] t, input logic [31:0] tt);
    logic [31:0] p;
    p = tt[31:16] * t;
    return p[31:16];
  endfunction

  // 6t^2 - 15t + 10 in q.16
  function automatic logic [19:0] quad(input logic [15:0] t, input logic [31:0] tt);
    logic [34:0] m6;
    logic [20:0] q;
    m6 = 35'(tt) * 35'd6;
    q  = 21'(m6[34:16]) + 21'd655360 - 21'(t) * 21'd15;
    return q[19:0];
  endfunction

  function automatic logic [16:0] fade_clip(input logic [15:0] t3, input logic [19:0] q);
    logic [35:0] p;
    p = t3 * q;
    return (p[35:16] > 20'd65536) ? 17'd65536 : p[32:16];
  endfunction

  item_t s1_item, s2_item, s3_item, s4_item, s5_item, s6_item, s7_item;
  item_t s1_next, s7_next;

  logic signed [PROD_W-1:0] s1_px, s1_py, px_next, py_next;
  logic [43:0]              freq_prod;
  logic [32:0]              amp_prod;

  logic [15:0] s2_fx, s2_fy;
  logic [31:0] s2_ttx, s2_tty;
  logic [2:0]  s2_sel [4];
  logic [2:0]  sel_next [4];
  logic [HASH_W-1:0] lx, ly, lx1, ly1, seed_lo;

  logic signed [17:0]       x0, x1, y0, y1;
  logic signed [GRAD_W-1:0] s3_grad [4];
  logic [15:0]              s3_t3x, s3_t3y;
  logic [19:0]              s3_qx, s3_qy;

  logic signed [GRAD_W-1:0] s4_grad [4];
  logic [16:0]              s4_fu, s4_fv;

  logic signed [BL_W-1:0] s5_r0, s5_r1;
  logic [16:0]            s5_fv;
  logic signed [BL_W-1:0] s6_noise;

  logic signed [37:0] wprod;
  logic               active;

  // stage 1: scale coordinates, advance frequency and amplitude
  always_comb begin
    px_next   = $signed(in_item.cx) * $signed({1'b0, in_item.freq});
    py_next   = $signed(in_item.cy) * $signed({1'b0, in_item.freq});
    freq_prod = in_item.freq * cfg.freq_gain;
    amp_prod  = in_item.amp * cfg.amp_gain;
    s1_next   = in_item;
    s1_next.freq   = (|freq_prod[43:40]) ? FREQ_SAT : freq_prod[39:12];
    s1_next.amp_nx = amp_prod[32:16];
  end

  // stage 2: lattice split, corner hashes, squares
  always_comb begin
    lx      = s1_px[48:28];
    ly      = s1_py[48:28];
    lx1     = lx + 21'd1;
    ly1     = ly + 21'd1;
    seed_lo = cfg.seed[HASH_W-1:0] + HASH_W'(OCT_IDX);
    sel_next[0] = corner_sel(lx,  ly,  seed_lo);
    sel_next[1] = corner_sel(lx1, ly,  seed_lo);
    sel_next[2] = corner_sel(lx,  ly1, seed_lo);
    sel_next[3] = corner_sel(lx1, ly1, seed_lo);
  end

  // stage 3: gradient dot products and fade polynomial terms
  always_comb begin
    x0 = $signed({2'b00, s2_fx});
    y0 = $signed({2'b00, s2_fy});
    x1 = x0 - 18'sd65536;
    y1 = y0 - 18'sd65536;
  end

  // stage 7: weight and accumulate
  always_comb begin
    active  = cfg.octave_count > CNT_W'(OCT_IDX);
    wprod   = s6_noise * $signed({1'b0, s6_item.amp});
    s7_next = s6_item;
    s7_next.amp = s6_item.amp_nx;
    if (active) begin
      s7_next.total  = s6_item.total + TOTAL_W'(wprod);
      s7_next.weight = s6_item.weight + WGT_W'(s6_item.amp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item.vld <= 1'b0;
      s2_item.vld <= 1'b0;
      s3_item.vld <= 1'b0;
      s4_item.vld <= 1'b0;
      s5_item.vld <= 1'b0;
      s6_item.vld <= 1'b0;
      s7_item.vld <= 1'b0;
    end else if (en) begin
      s1_item <= s1_next;
      s2_item <= s1_item;
      s3_item <= s2_item;
      s4_item <= s3_item;
      s5_item <= s4_item;
      s6_item <= s5_item;
      s7_item <= s7_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= px_next;
      s1_py  <= py_next;
      s2_fx  <= s1_px[27:12];
      s2_fy  <= s1_py[27:12];
      s2_ttx <= s1_px[27:12] * s1_px[27:12];
      s2_tty <= s1_py[27:12] * s1_py[27:12];
      for (int c = 0; c < 4; c++) begin
        s2_sel[c]  <= sel_next[c];
        s4_grad[c] <= s3_grad[c];
      end
      s3_grad[0] <= grad(s2_sel[0], x0, y0);
      s3_grad[1] <= grad(s2_sel[1], x1, y0);
      s3_grad[2] <= grad(s2_sel[2], x0, y1);
      s3_grad[3] <= grad(s2_sel[3], x1, y1);
      s3_t3x <= cube(s2_fx, s2_ttx);
      s3_t3y <= cube(s2_fy, s2_tty);
      s3_qx  <= quad(s2_fx, s2_ttx);
      s3_qy  <= quad(s2_fy, s2_tty);
      s4_fu  <= fade_clip(s3_t3x, s3_qx);
      s4_fv  <= fade_clip(s3_t3y, s3_qy);
      s5_r0  <= blend(BL_W'(s4_grad[0]), BL_W'(s4_grad[1]), s4_fu);
      s5_r1  <= blend(BL_W'(s4_grad[2]), BL_W'(s4_grad[3]), s4_fu);
      s5_fv  <= s4_fv;
      s6_noise <= blend(s5_r0, s5_r1, s5_fv);
    end
  end

  assign out_item = s7_item;

endmodule

// ----- src/fgn_div.sv -----
// pipelined restoring divider: total / (2 * weight), truncated and saturated
`timescale 1ns / 1ps

module fgn_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [fgn_pkg::TOTAL_W-1:0]     in_total,
  input  logic [fgn_pkg::WGT_W-1:0]              in_weight,
  output logic                                   out_vld,
  output logic signed [fgn_pkg::NOISE_W-1:0]     out_value
);
  import fgn_pkg::*;

  localparam int DEN_W = WGT_W + 1;

  logic                 st_vld  [QUOT_W+1];
  logic [TOTAL_W-1:0]   st_rem  [QUOT_W+1];
  logic [QUOT_W-1:0]    st_q    [QUOT_W+1];
  logic [DEN_W-1:0]     st_den  [QUOT_W+1];
  logic                 st_neg  [QUOT_W+1];
  logic                 st_sat  [QUOT_W+1];
  logic                 st_zero [QUOT_W+1];

  logic [TOTAL_W-1:0] mag;
  logic [DEN_W-1:0]   den;
  logic               ovf;
  logic [QUOT_W-1:0]  q_fin;
  logic signed [NOISE_W-1:0] value_next;

  // entry: magnitude, doubled divisor, quotient overflow check
  always_comb begin
    mag = in_total[TOTAL_W-1] ? TOTAL_W'(-in_total) : TOTAL_W'(in_total);
    den = {in_weight, 1'b0};
    ovf = mag >= (TOTAL_W'(den) << QUOT_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld[0] <= 1'b0;
    end else if (en) begin
      st_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem[0]  <= mag;
      st_q[0]    <= '0;
      st_den[0]  <= den;
      st_neg[0]  <= in_total[TOTAL_W-1];
      st_sat[0]  <= ovf;
      st_zero[0] <= (in_weight == '0);
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QUOT_W; k++) begin : g_bit
    localparam int B = QUOT_W - 1 - k;
    logic [TOTAL_W-1:0] trial;
    logic               ge;
    logic [QUOT_W-1:0]  q_next;

    always_comb begin
      trial     = TOTAL_W'(st_den[k]) << B;
      ge        = st_rem[k] >= trial;
      q_next    = st_q[k];
      q_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k+1] <= 1'b0;
      end else if (en) begin
        st_vld[k+1] <= st_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1]  <= ge ? st_rem[k] - trial : st_rem[k];
        st_q[k+1]    <= q_next;
        st_den[k+1]  <= st_den[k];
        st_neg[k+1]  <= st_neg[k];
        st_sat[k+1]  <= st_sat[k];
        st_zero[k+1] <= st_zero[k];
      end
    end
  end

  // sign, zero weight and saturation
  always_comb begin
    q_fin = st_q[QUOT_W];
    if (st_zero[QUOT_W]) begin
      value_next = '0;
    end else if (!st_neg[QUOT_W]) begin
      value_next = (st_sat[QUOT_W] || q_fin > QUOT_W'(OUT_MAX)) ?
                   OUT_MAX : $signed(q_fin[NOISE_W-1:0]);
    end else begin
      value_next = (st_sat[QUOT_W] || q_fin > QUOT_W'(19'd131072)) ?
                   OUT_MIN : -$signed(q_fin[NOISE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= st_vld[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= value_next;
    end
  end

endmodule

// ----- verif/fgn_checker.sv -----
// noise predictor and result checker for the fractal gradient noise unit
`timescale 1ns / 1ps

module fgn_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [fgn_pkg::SEED_W-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [31:0]                  coord_x,
  input  logic signed [31:0]                  coord_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [fgn_pkg::NOISE_W-1:0]  noise_value,
  output int                                  errors,
  output int                                  pending,
  output int                                  results_seen
);
  import fgn_pkg::*;

  logic [3:0]  octaves_q;
  logic [15:0] lacunarity_q;
  logic [15:0] persistence_q;
  logic [31:0] seed_q;
  logic signed [NOISE_W-1:0] noise_fifo[$];

  function automatic longint floor_shift16(longint v);
    return v >>> 16;
  endfunction

  function automatic logic [7:0] lattice_hash(logic [31:0] lx, logic [31:0] ly,
                                              logic [31:0] s);
    logic [31:0] h;
    h = s ^ (lx * HASH_C1);
    h = h ^ (ly * HASH_C2);
    h = (h ^ (h >> HASH_SHIFT)) * HASH_C3;
    return h[7:0];
  endfunction

  function automatic longint quintic(longint t);
    longint t2, t3, q, f;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    q = (6 * t * t - 15 * (t << 16) + 10 * (longint'(1) << 32)) >>> 16;
    f = (t3 * q) >> 16;
    return (f > 65536) ? 65536 : f;
  endfunction

  function automatic longint grad(logic [7:0] h, longint x, longint y);
    longint u, v;
    u = (h[2] == 1'b0) ? x : y;
    v = (h[2] == 1'b0) ? y : x;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint lerp16(longint a, longint b, longint t);
    return a + floor_shift16((b - a) * t);
  endfunction

  function automatic longint single_octave(longint cx, longint cy, longint freq,
                                           logic [31:0] s);
    logic [63:0] px, py;
    logic [31:0] lx, ly;
    longint fx, fy, u, v, g00, g10, g01, g11;
    px = cx * freq;
    py = cy * freq;
    fx = px[27:12];
    fy = py[27:12];
    lx = px[59:28];
    ly = py[59:28];
    u = quintic(fx);
    v = quintic(fy);
    g00 = grad(lattice_hash(lx, ly, s), fx, fy);
    g10 = grad(lattice_hash(lx + 32'd1, ly, s), fx - 65536, fy);
    g01 = grad(lattice_hash(lx, ly + 32'd1, s), fx, fy - 65536);
    g11 = grad(lattice_hash(lx + 32'd1, ly + 32'd1, s), fx - 65536, fy - 65536);
    return lerp16(lerp16(g00, g10, u), lerp16(g01, g11, u), v);
  endfunction

  function automatic logic signed [NOISE_W-1:0] fractal_noise(longint cx, longint cy);
    longint freq, amp, total, wsum, r, nf;
    int n;
    freq = 4096; amp = 65536; total = 0; wsum = 0; r = 0;
    n = (octaves_q > 8) ? 8 : octaves_q;
    for (int i = 0; i < n; i++) begin
      total += single_octave(cx, cy, freq, seed_q + 32'(i)) * amp;
      wsum += amp;
      amp = (amp * persistence_q) >> 16;
      nf = (freq * lacunarity_q) >> 12;
      freq = (nf > 64'h0FFFFFFF) ? 64'h0FFFFFFF : nf;
    end
    if (wsum > 0) begin
      r = total / (2 * wsum);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
    end
    return r[NOISE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      octaves_q <= 4'd4; lacunarity_q <= 16'd8192; persistence_q <= 16'd32768;
      seed_q <= '0;
      errors <= 0; results_seen <= 0;
      noise_fifo.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OCTAVES:   octaves_q <= cfg_data[3:0];
          CFG_FREQ_GAIN: lacunarity_q <= cfg_data[15:0];
          CFG_AMP_GAIN:  persistence_q <= cfg_data[15:0];
          CFG_SEED:      seed_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) noise_fifo.push_back(fractal_noise(coord_x, coord_y));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (noise_fifo.size() == 0) begin
          $display("%0t: unexpected noise result %0d", $time, noise_value);
          errors <= errors + 1;
        end else begin
          if (noise_fifo[0] !== noise_value) begin
            $display("%0t: noise_value mismatch expected %0d actual %0d", $time,
                     noise_fifo[0], noise_value);
            errors <= errors + 1;
          end
          void'(noise_fifo.pop_front());
        end
      end
    end
  end

  assign pending = noise_fifo.size();
endmodule

// ----- verif/tb.sv -----
// stimulus and verdict for the fractal gradient noise unit
`timescale 1ns / 1ps

module tb;
  import fgn_pkg::*;

  localparam int LATENCY   = 7 * 8 + 21;
  localparam int WATCHDOG  = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NOISE_W-1:0] noise_value;
  int errors, pending, results_seen;
  int idle_in_pct = 0;      // sender gap probability
  int stall_out_pct = 0;    // receiver stall probability
  int quiet_cycles = 0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fractal_gradient_noise_2d_unit uut (.*);

  fgn_checker chk (.*);

  // receiver stall pattern follows the current phase
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_out_pct);

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one transaction with an optional random gap ahead of it
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // drop valid and let everything in flight drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(logic [3:0] oct, logic [15:0] lac, logic [15:0] per,
                              logic [31:0] s);
    write_reg(CFG_OCTAVES, 32'(oct));
    write_reg(CFG_FREQ_GAIN, 32'(lac));
    write_reg(CFG_AMP_GAIN, 32'(per));
    write_reg(CFG_SEED, s);
    @(posedge clk);
  endtask

  // coordinates: mostly modest values with full fraction bits, some full range
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(16'hFFFF))) - 32'h8000 << 8;
      default: return {{12{$urandom_range(1)==1}}, 20'($urandom())};
    endcase
  endfunction

  initial begin
    int n_rand;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extremes of the coordinates, lattice edges
    send_point(32'h0, 32'h0);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7FFFFFFF);
    send_point(32'hFFFFFFFF, 32'h00000001);
    send_point(32'h00010000, 32'hFFFF0000);
    send_point(32'h0000FFFF, 32'h00008000);
    send_point(32'hAAAAAAAA, 32'h55555555);
    drain();

    // zero octaves must give zero
    program_regs(4'd0, 16'd8192, 16'd32768, 32'h0);
    send_point(32'h12345678, 32'h9ABCDEF0);
    send_point(32'h7FFFFFFF, 32'h80000000);
    drain();
    // octave count above the maximum, huge lacunarity, zero persistence
    program_regs(4'd15, 16'hFFFF, 16'h0000, 32'hFFFFFFFF);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h00010001);
    send_point(32'h00123456, 32'hFFEDCBA9);
    drain();
    // all octaves with full persistence and zero lacunarity
    program_regs(4'd8, 16'h0000, 16'hFFFF, 32'h80000000);
    send_point(32'h7FFFFFFF, 32'h80000000);
    send_point(32'h00018000, 32'hFFFE8000);
    drain();
    // single octave: rough raw noise at unit lacunarity and zero persistence
    program_regs(4'd1, 16'd4096, 16'd0, 32'h5A5A5A5A);
    for (int i = 0; i < 8; i++) send_point($urandom(), $urandom());
    drain();

    // random phases, each with its own settings and idling pattern
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 77; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 77; end
        default: begin idle_in_pct = 17; stall_out_pct = 17; end
      endcase
      program_regs(4'($urandom_range(15)), 16'($urandom()), 16'($urandom()), $urandom());
      n_rand = 120;
      for (int i = 0; i < n_rand; i++) begin
        send_point(pick_coord(), pick_coord());
        // in phase 3 only, hold off once mid phase until every result is back
        if (i == n_rand / 2 && phase == 3) drain();
      end
      drain();
    end

    $display("covered %0d samples, %0d results, over zero to maximum octaves,", sent,
             results_seen);
    $display("extreme gains and seeds, with sender gaps and receiver stalls");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- sim.f -----
src/fgn_pkg.sv
src/fgn_octave.sv
src/fgn_div.sv
src/fractal_gradient_noise_2d_unit.sv
verif/fgn_checker.sv
verif/tb.sv
